>>> hw/rtl/chi_pkg.sv
// Shared types, constants and helpers for the chained hash index.
// No dependencies; every other file in hw/rtl imports this package.
package chi_pkg;

  localparam int BUCKETS   = 256;
  localparam int ENTRIES   = 1024;
  localparam int KEY_BYTES = 8;
  localparam int QDEPTH    = 2;

  localparam int IW = $clog2(ENTRIES);   // node and item number width
  localparam int PW = IW + 1;            // pointer width, includes the empty code
  localparam int BW = $clog2(BUCKETS);   // bucket number width

  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_KEY_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

  // Effective settings, already clamped.
  typedef struct packed {
    logic       key_mode;
    logic [3:0] key_len;
    logic [8:0] buckets;
  } cfg_t;

  // One classified operation handed from front to back.
  typedef struct packed {
    logic [1:0]    op;
    logic [63:0]   key;
    logic [9:0]    idx;
    logic          bad;
    logic [BW-1:0] bucket;
  } q_item_t;

  function automatic logic key_match(logic [63:0] a, logic [63:0] b, logic mode,
                                     logic [3:0] n);
    logic done;
    logic m;
    done = 1'b0;
    m    = 1'b1;
    if (!mode) begin
      m = (a[31:0] == b[31:0]);
    end else begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (!done && (4'(i) < n)) begin
          if (a[8*i +: 8] != b[8*i +: 8]) begin
            m    = 1'b0;
            done = 1'b1;
          end else if (a[8*i +: 8] == 8'd0) begin
            done = 1'b1;
          end
        end
      end
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/chi_front.sv
// Front end: accepts operations, hashes the key and reduces it to a bucket.
// Depends on chi_pkg; keeps its own copy of the key store for delete hashing.
module chi_front import chi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] key_value,
  input  logic [9:0]  item_index,
  output logic        q_valid,
  input  logic        q_ready,
  output q_item_t     q_item
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_READ = 3'd1;
  localparam logic [2:0] F_HASH = 3'd2;
  localparam logic [2:0] F_MOD  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]  state;
  logic [1:0]  op;
  logic [63:0] key;
  logic [63:0] hkey;
  logic [9:0]  idx;
  logic        bad;
  logic [31:0] h;
  logic [3:0]  byte_i;
  logic [8:0]  rem;
  logic [3:0]  cnt;

  logic [63:0] key_copy [ENTRIES];
  logic [63:0] kc_rd;

  logic        accept;
  logic        idx_ok;
  logic [7:0]  cur_byte;
  logic [31:0] h_step;
  logic        hash_end;
  logic [8:0]  t1;
  logic [8:0]  t2;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = (32'(item_index) < ENTRIES);

  assign cur_byte = hkey[8*byte_i[2:0] +: 8];
  assign h_step   = 32'(cur_byte) + (h << 5) - h;
  assign hash_end = (byte_i >= cfg.key_len) || (cur_byte == 8'd0);

  // two restoring remainder steps a cycle
  always_comb begin
    t1 = {rem[7:0], h[31]};
    if (t1 >= cfg.buckets) t1 = t1 - cfg.buckets;
    t2 = {t1[7:0], h[30]};
    if (t2 >= cfg.buckets) t2 = t2 - cfg.buckets;
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_INSERT) && idx_ok) begin
      key_copy[item_index[IW-1:0]] <= key_value;
    end
    kc_rd <= key_copy[item_index[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            op     <= operation;
            key    <= key_value;
            hkey   <= key_value;
            idx    <= item_index;
            bad    <= ((operation == OP_INSERT) || (operation == OP_DELETE)) && !idx_ok;
            h      <= '0;
            byte_i <= '0;
            rem    <= '0;
            cnt    <= '0;
            if ((operation == OP_CLEAR) ||
                (((operation == OP_INSERT) || (operation == OP_DELETE)) && !idx_ok)) begin
              state <= F_PUSH;
            end else if (operation == OP_DELETE) begin
              state <= F_READ;
            end else begin
              state <= F_HASH;
            end
          end
        end
        F_READ: begin
          hkey  <= kc_rd;
          state <= F_HASH;
        end
        F_HASH: begin
          if (!cfg.key_mode) begin
            h     <= hkey[31:0];
            state <= F_MOD;
          end else if (hash_end) begin
            state <= F_MOD;
          end else begin
            h      <= h_step;
            byte_i <= byte_i + 4'd1;
          end
        end
        F_MOD: begin
          h   <= h << 2;
          rem <= t2;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign q_valid       = (state == F_PUSH);
  assign q_item.op     = op;
  assign q_item.key    = key;
  assign q_item.idx    = idx;
  assign q_item.bad    = bad;
  assign q_item.bucket = rem[BW-1:0];

endmodule

>>> hw/rtl/chi_queue.sv
// Short queue between the front and back ends.
// Depends on chi_pkg for the item type and depth.
module chi_queue import chi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  q_item_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output q_item_t out_item
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t        slots [QDEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != CW'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/chi_back.sv
// Back end: bucket heads, node pool, chain walk and the result register.
// Depends on chi_pkg; holds the key store copy used for lookup compares.
module chi_back import chi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  q_item_t    q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] result_index,
  output logic [1:0] status
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_POP  = 3'd1;
  localparam logic [2:0] B_HEAD = 3'd2;
  localparam logic [2:0] B_NODE = 3'd3;
  localparam logic [2:0] B_ITEM = 3'd4;
  localparam logic [2:0] B_KEY  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]    state;
  logic [1:0]    op;
  logic [63:0]   key;
  logic [9:0]    idx;
  logic [BW-1:0] bucket;
  logic [PW-1:0] node;
  logic [PW-1:0] prev;
  logic [PW-1:0] nxt;
  logic [IW-1:0] it;
  logic [PW-1:0] steps;
  logic [PW-1:0] fc;
  logic [PW-1:0] lwm;
  logic [9:0]    res;
  logic [1:0]    st;
  logic          hv [BUCKETS];

  logic [PW-1:0] head_mem [BUCKETS];
  logic [PW-1:0] next_mem [ENTRIES];
  logic [IW-1:0] item_mem [ENTRIES];
  logic [IW-1:0] stk_mem  [ENTRIES];
  logic [63:0]   ks_mem   [ENTRIES];

  logic [PW-1:0] head_rd;
  logic [PW-1:0] next_rd;
  logic [IW-1:0] item_rd;
  logic [IW-1:0] stk_rd;
  logic [63:0]   ks_rd;

  logic          take;
  logic [PW-1:0] fc_m1;
  logic [IW-1:0] pop_node;
  logic [PW-1:0] head_cur;
  logic          head_we;
  logic [PW-1:0] head_wd;
  logic          next_we;
  logic [IW-1:0] next_wa;
  logic [PW-1:0] next_wd;
  logic          stk_we;
  logic          ks_we;
  logic          unlink;

  assign q_ready  = (state == B_IDLE);
  assign take     = q_valid && q_ready;
  assign fc_m1    = fc - 1'b1;
  assign pop_node = (fc_m1 < lwm) ? (IW'(ENTRIES - 1) - fc_m1[IW-1:0]) : stk_rd;
  assign head_cur = hv[bucket] ? head_rd : NIL;
  assign unlink   = (state == B_ITEM) && (op == OP_DELETE) && (item_rd == idx[IW-1:0]);

  always_comb begin
    head_we = 1'b0;
    head_wd = {1'b0, pop_node};
    next_we = 1'b0;
    next_wa = pop_node;
    next_wd = head_cur;
    if (state == B_POP) begin
      head_we = 1'b1;
      next_we = 1'b1;
    end else if (unlink) begin
      if (prev == NIL) begin
        head_we = 1'b1;
        head_wd = next_rd;
      end else begin
        next_we = 1'b1;
        next_wa = prev[IW-1:0];
        next_wd = next_rd;
      end
    end
  end

  assign stk_we = unlink && (fc < PW'(ENTRIES));
  assign ks_we  = take && (q_item.op == OP_INSERT) && !q_item.bad;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[bucket] <= head_wd;
    head_rd <= head_mem[q_item.bucket];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[node[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == B_POP) item_mem[pop_node] <= idx[IW-1:0];
    item_rd <= item_mem[node[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[fc[IW-1:0]] <= node[IW-1:0];
    stk_rd <= stk_mem[fc_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ks_we) ks_mem[q_item.idx[IW-1:0]] <= q_item.key;
    ks_rd <= ks_mem[item_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      fc        <= PW'(ENTRIES);
      lwm       <= PW'(ENTRIES);
      out_valid <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) hv[i] <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != B_OUT)) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (take) begin
            op     <= q_item.op;
            key    <= q_item.key;
            idx    <= q_item.idx;
            bucket <= q_item.bucket;
            if (q_item.op == OP_CLEAR) begin
              for (int i = 0; i < BUCKETS; i++) hv[i] <= 1'b0;
              fc    <= PW'(ENTRIES);
              lwm   <= PW'(ENTRIES);
              res   <= 10'd0;
              st    <= ST_DONE;
              state <= B_OUT;
            end else if (q_item.bad) begin
              res   <= q_item.idx;
              st    <= ST_MISS;
              state <= B_OUT;
            end else if (q_item.op == OP_INSERT) begin
              res <= q_item.idx;
              if (fc == '0) begin
                st    <= ST_FULL;
                state <= B_OUT;
              end else begin
                st    <= ST_MISS;
                state <= B_POP;
              end
            end else begin
              res   <= (q_item.op == OP_LOOKUP) ? 10'd0 : q_item.idx;
              st    <= ST_MISS;
              state <= B_HEAD;
            end
          end
        end
        B_POP: begin
          hv[bucket] <= 1'b1;
          fc         <= fc_m1;
          if (fc_m1 < lwm) lwm <= fc_m1;
          st         <= ST_DONE;
          state      <= B_OUT;
        end
        B_HEAD: begin
          node  <= head_cur;
          prev  <= NIL;
          steps <= '0;
          state <= B_NODE;
        end
        B_NODE: begin
          if ((node == NIL) || (steps == PW'(ENTRIES))) state <= B_OUT;
          else state <= B_ITEM;
        end
        B_ITEM: begin
          nxt <= next_rd;
          if (op == OP_LOOKUP) begin
            it    <= item_rd;
            state <= B_KEY;
          end else if (unlink) begin
            if (stk_we) fc <= fc + 1'b1;
            st    <= ST_DONE;
            state <= B_OUT;
          end else begin
            prev  <= node;
            node  <= next_rd;
            steps <= steps + 1'b1;
            state <= B_NODE;
          end
        end
        B_KEY: begin
          if (key_match(ks_rd, key, cfg.key_mode, cfg.key_len)) begin
            res   <= 10'(it);
            st    <= ST_DONE;
            state <= B_OUT;
          end else begin
            node  <= nxt;
            steps <= steps + 1'b1;
            state <= B_NODE;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_index <= res;
            status       <= st;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/chained_hash_index_core.sv
// Flow: the front accepts an item, reads the stored key on delete, hashes the key,
//   reduces the hash two bits a cycle in the modulo unit and hands it to the queue
//   (clear and out-of-range insert or delete items skip to the transfer); the back
//   pops a node or reads the bucket head, walks the chain with one memory read each
//   step (node, item and key on lookup, node and item on delete), then sends the result.
// Reset (rst, synchronous): empties all chains through per-bucket valid bits, refills
//   the node pool at once, restores key_mode 0, key_length 8, bucket_count 256.
module chained_hash_index_core import chi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] key_value,
  input  logic [9:0]  item_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  result_index,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // Configuration registers, raw as written.
  logic       key_mode;
  logic [3:0] key_length;
  logic [8:0] bucket_count;
  cfg_t       cfg;

  // Front to queue, queue to back.
  logic    fq_valid;
  logic    fq_ready;
  q_item_t fq_item;
  logic    qb_valid;
  logic    qb_ready;
  q_item_t qb_item;

  // Writes are always taken; they must only arrive while the block is idle, which it does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode     <= 1'b0;
      key_length   <= 4'd8;
      bucket_count <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_MODE:     key_mode     <= cfg_data[0];
        CFG_KEY_LENGTH:   key_length   <= cfg_data[3:0];
        CFG_BUCKET_COUNT: bucket_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp once here: zero buckets act as one, oversized values saturate.
  always_comb begin
    cfg.key_mode = key_mode;
    cfg.key_len  = (32'(key_length) > KEY_BYTES) ? 4'(KEY_BYTES) : key_length;
    if (bucket_count == 9'd0)               cfg.buckets = 9'd1;
    else if (32'(bucket_count) > BUCKETS)   cfg.buckets = 9'(BUCKETS);
    else                                    cfg.buckets = bucket_count;
  end

  // Front: accept, hash and reduce to a bucket.
  chi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .key_value  (key_value),
    .item_index (item_index),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_item     (fq_item)
  );

  // Decouple: the front hashes the next item while the back walks a chain.
  chi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // Back: update chains and node pool, hold the result until its transfer.
  chi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_item       (qb_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_index (result_index),
    .status       (status)
  );

`ifndef ASSERT_OFF
  // Front holds an offered item steady until the queue takes it.
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (fq_valid && !fq_ready) |=> (fq_valid && $stable(fq_item)))
    else $error("front dropped or changed an item before its transfer");

  // Reset leaves the block ready for input with no result pending.
  a_reset_rest: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not at rest after reset");
`endif

endmodule

>>> verif/tb_chained_hash_index_core.sv
// Self-checking testbench for chained_hash_index_core: insert, lookup, delete and clear
// against a predicted hash index. Depends on chi_pkg and the core RTL only.
module tb_chained_hash_index_core;
  import chi_pkg::*;

  typedef struct {
    logic [9:0] idx;
    logic [1:0] st;
  } outcome_t;

  // Scoreboard: holds its own copy of the index and the queue of outcomes still due.
  class index_scoreboard;
    logic       mode;
    logic [3:0] key_len;
    logic [8:0] bkt_cnt;
    int unsigned head[BUCKETS];
    int unsigned nxt[ENTRIES];
    int unsigned itm[ENTRIES];
    logic [63:0] store[ENTRIES];
    int unsigned free_stk[ENTRIES];
    int unsigned free_cnt;
    outcome_t    due[$];
    int          errors;

    function new();
      mode = 1'b0;
      key_len = 4'd8;
      bkt_cnt = 9'd256;
      errors = 0;
      foreach (store[i]) store[i] = '0;
      empty_chains();
    endfunction

    function void empty_chains();
      foreach (head[i]) head[i] = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) free_stk[i] = ENTRIES - 1 - i;
      free_cnt = ENTRIES;
    endfunction

    function void set_cfg(logic [1:0] reg_idx, logic [8:0] data);
      case (reg_idx)
        CFG_KEY_MODE:     mode = data[0];
        CFG_KEY_LENGTH:   key_len = data[3:0];
        CFG_BUCKET_COUNT: bkt_cnt = data;
        default: ;
      endcase
    endfunction

    function int unsigned hashed_bytes();
      return (key_len > KEY_BYTES) ? KEY_BYTES : key_len;
    endfunction

    function int unsigned bucket_for(logic [63:0] k);
      logic [31:0] h;
      int unsigned nb;
      h = '0;
      nb = (bkt_cnt == 0) ? 1 : ((bkt_cnt > BUCKETS) ? BUCKETS : bkt_cnt);
      if (!mode) begin
        h = k[31:0];
      end else begin
        for (int i = 0; i < hashed_bytes(); i++) begin
          if (k[8*i +: 8] == 8'd0) break;
          h = {24'd0, k[8*i +: 8]} + 32'd31 * h;
        end
      end
      return h % nb;
    endfunction

    function bit same_key(logic [63:0] a, logic [63:0] b);
      if (!mode) return a[31:0] == b[31:0];
      for (int i = 0; i < hashed_bytes(); i++) begin
        if (a[8*i +: 8] != b[8*i +: 8]) return 0;
        if (a[8*i +: 8] == 8'd0) return 1;
      end
      return 1;
    endfunction

    // Note an accepted input transfer and queue the outcome it must give.
    function void note_item(logic [1:0] op, logic [63:0] k, logic [9:0] idx);
      outcome_t o;
      int unsigned b, node, prev, steps;
      o.idx = idx;
      o.st  = ST_DONE;
      case (op)
        OP_CLEAR: begin
          empty_chains();
          o.idx = '0;
        end
        OP_LOOKUP: begin
          o.idx = '0;
          o.st  = ST_MISS;
          node  = head[bucket_for(k)];
          steps = 0;
          while (node < ENTRIES && steps < ENTRIES) begin
            if (same_key(store[itm[node]], k)) begin
              o.idx = itm[node];
              o.st  = ST_DONE;
              break;
            end
            node = nxt[node];
            steps++;
          end
        end
        OP_INSERT: begin
          store[idx] = k;
          if (free_cnt == 0) begin
            o.st = ST_FULL;
          end else begin
            b = bucket_for(k);
            free_cnt--;
            node = free_stk[free_cnt];
            itm[node] = idx;
            nxt[node] = head[b];
            head[b] = node;
          end
        end
        default: begin
          b = bucket_for(store[idx]);
          node = head[b];
          prev = ENTRIES;
          steps = 0;
          o.st = ST_MISS;
          while (node < ENTRIES && steps < ENTRIES) begin
            if (itm[node] == idx) begin
              if (prev == ENTRIES) head[b] = nxt[node];
              else nxt[prev] = nxt[node];
              if (free_cnt < ENTRIES) free_stk[free_cnt++] = node;
              o.st = ST_DONE;
              break;
            end
            prev = node;
            node = nxt[node];
            steps++;
          end
        end
      endcase
      due.push_back(o);
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void check_result(logic [9:0] ri, logic [1:0] st);
      outcome_t o;
      if (due.size() == 0) begin
        report($sformatf("unexpected result idx=%0d status=%0d", ri, st));
        return;
      end
      o = due.pop_front();
      if (ri !== o.idx) report($sformatf("result_index %0d, want %0d", ri, o.idx));
      if (st !== o.st) report($sformatf("status %0d, want %0d", st, o.st));
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [63:0] key_value;
  logic [9:0]  item_index;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  result_index;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  index_scoreboard sb;
  int          cycles;
  bit          idling;      // when clear, both sides run without gaps
  int          hold_off;    // one-shot long receiver stall, in cycles
  logic [63:0] key_pool[12];
  logic [9:0]  written[$];  // indices whose key store entry holds a key

  chained_hash_index_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .key_value(key_value), .item_index(item_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_index(result_index), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    return idling ? $urandom_range(0, 16) : 0;
  endfunction

  // Offer one item and hold it until the transfer happens. Valid only drops when a
  // gap follows, so back-to-back items keep it high without a second assignment.
  task automatic send_item(logic [1:0] op, logic [63:0] k, logic [9:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    key_value  <= k;
    item_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, k, idx);
    if (op == OP_INSERT) written.push_back(idx);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller drops it after the last.
  task automatic write_cfg(logic [1:0] reg_idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cfg(reg_idx, data);
  endtask

  // Pull results with random stalls; honour a pending long hold-off first.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = (hold_off > 0) ? hold_off : draw_gap();
      hold_off = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(result_index, status);
    end
  end

  function automatic logic [63:0] fresh_key(bit zero_byte);
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (zero_byte) k[8*$urandom_range(0, 7) +: 8] = 8'd0;
    return k;
  endfunction

  // Mostly keys from a small pool so lookups hit and chains collide.
  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 11)];
    return fresh_key($urandom_range(0, 3) == 0);
  endfunction

  task automatic random_items(int count);
    int  r;
    logic [9:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(OP_CLEAR, fresh_key(0), 10'($urandom));
      end else if (r < 25 && written.size() != 0) begin
        send_item(OP_DELETE, fresh_key(0), written[$urandom_range(0, written.size() - 1)]);
      end else if (r < 55) begin
        send_item(OP_LOOKUP, pick_key(), 10'($urandom));
      end else begin
        idx = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 63)) : 10'($urandom);
        send_item(OP_INSERT, pick_key(), idx);
      end
    end
  endtask

  initial begin
    int settings[9][3] = '{
      '{0, 8, 256}, '{1, 8, 256}, '{1, 0, 7}, '{1, 1, 1}, '{1, 15, 0},
      '{0, 3, 300}, '{1, 4, 13}, '{0, 8, 1}, '{1, 8, 511}
    };
    sb = new();
    cycles = 0;
    idling = 1'b1;
    hold_off = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_INSERT;
    key_value = '0;
    item_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY_MODE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, duplicates, newest-first lookup, absent delete, clear.
    send_item(OP_INSERT, 64'd0, 10'd0);
    send_item(OP_INSERT, '1, 10'd1023);
    send_item(OP_LOOKUP, 64'd0, 10'd0);
    send_item(OP_LOOKUP, '1, 10'd1023);
    send_item(OP_LOOKUP, 64'h1234_5678, 10'd0);
    send_item(OP_INSERT, 64'hABCD_0000_0000_0000, 10'd5);
    send_item(OP_LOOKUP, 64'd0, 10'd0);
    send_item(OP_DELETE, 64'd0, 10'd5);
    send_item(OP_DELETE, 64'd0, 10'd5);
    send_item(OP_LOOKUP, 64'd0, 10'd0);
    send_item(OP_DELETE, 64'd0, 10'd1023);
    send_item(OP_CLEAR, '1, 10'd1023);
    send_item(OP_LOOKUP, 64'd0, 10'd0);
    send_item(OP_DELETE, 64'd0, 10'd0);
    wait_drained();

    // Random phases over a range of settings, extremes included.
    foreach (settings[p]) begin
      write_cfg(CFG_KEY_MODE, 9'(settings[p][0]));
      write_cfg(CFG_KEY_LENGTH, 9'(settings[p][1]));
      write_cfg(CFG_BUCKET_COUNT, 9'(settings[p][2]));
      cfg_valid <= 1'b0;
      for (int i = 0; i < 12; i++) key_pool[i] = fresh_key($urandom_range(0, 1));
      idling = (p % 3 != 1);
      if (p == 2) hold_off = 400;
      random_items(90);
      send_item(OP_CLEAR, fresh_key(0), 10'($urandom));
      wait_drained();
    end

    // Exhaust the node pool, then free a few nodes and reuse them.
    write_cfg(CFG_KEY_MODE, 9'd0);
    write_cfg(CFG_KEY_LENGTH, 9'd8);
    write_cfg(CFG_BUCKET_COUNT, 9'd256);
    cfg_valid <= 1'b0;
    idling = 1'b0;
    for (int i = 0; i < ENTRIES + 6; i++) send_item(OP_INSERT, fresh_key(0), 10'($urandom));
    idling = 1'b1;
    for (int i = 0; i < 12; i++) key_pool[i] = sb.store[written[$urandom_range(0, written.size() - 1)]];
    random_items(40);
    send_item(OP_CLEAR, fresh_key(0), 10'd0);
    wait_drained();
    repeat (60) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
